### rtl/arm_pkg.sv
`default_nettype none

package arm_pkg;

  // Default playback buffer depth
  localparam int BUF_DEPTH_DEF = 128;

  // Request kinds
  typedef enum logic [1:0] {
    REQ_EDGE   = 2'd0,
    REQ_SAMPLE = 2'd1,
    REQ_HALF   = 2'd2,
    REQ_FULL   = 2'd3
  } req_t;

  // Detected sample-rate codes
  localparam logic [2:0] RATE_NONE = 3'd0;
  localparam logic [2:0] RATE_8K   = 3'd1;
  localparam logic [2:0] RATE_16K  = 3'd2;
  localparam logic [2:0] RATE_22K  = 3'd3;
  localparam logic [2:0] RATE_33K  = 3'd4;
  localparam logic [2:0] RATE_44K  = 3'd5;
  localparam logic [2:0] RATE_48K  = 3'd6;

  // PLL multiplier after reset
  localparam logic [8:0] MULT_RESET = 9'd330;

  // Multiplier threshold sets
  typedef enum logic [1:0] {
    SET_8K  = 2'd0,
    SET_44K = 2'd1,
    SET_48K = 2'd2
  } thr_set_t;

  typedef enum logic [1:0] {
    THR_MIN = 2'd0,
    THR_MID = 2'd1,
    THR_MAX = 2'd2,
    THR_OVR = 2'd3
  } thr_sel_t;

  // Result fields except the buffer slot, whose width follows the depth
  typedef struct packed {
    logic        write_enable;
    logic [15:0] write_value;
    logic        clear_buffer;
    logic        pll_update;
    logic [8:0]  pll_mult;
    logic [2:0]  rate_code;
  } res_t;

  // Threshold table lookup
  function automatic logic [8:0] thr_value(thr_set_t s, thr_sel_t sel);
    logic [8:0] v;
    v = MULT_RESET;
    unique case (s)
      SET_8K: begin
        unique case (sel)
          THR_MIN: v = 9'd56;
          THR_MID: v = 9'd57;
          THR_MAX: v = 9'd58;
          THR_OVR: v = 9'd60;
        endcase
      end
      SET_44K: begin
        unique case (sel)
          THR_MIN: v = 9'd315;
          THR_MID: v = 9'd316;
          THR_MAX: v = 9'd317;
          THR_OVR: v = 9'd320;
        endcase
      end
      SET_48K: begin
        unique case (sel)
          THR_MIN: v = 9'd342;
          THR_MID: v = 9'd343;
          THR_MAX: v = 9'd345;
          THR_OVR: v = 9'd360;
        endcase
      end
      default: v = MULT_RESET;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

### rtl/arm_core.sv
`default_nettype none

// Controller state and the single-pass decision logic for one transaction.
module arm_core #(
  parameter int BUF_DEPTH = arm_pkg::BUF_DEPTH_DEF,
  parameter int PTR_W     = $clog2(BUF_DEPTH + 1),
  parameter int IDX_W     = $clog2(BUF_DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              fire,
  input  wire logic [1:0]        req_type,
  input  wire logic [31:0]       timestamp_us,
  input  wire logic [31:0]       sample_word,
  output arm_pkg::res_t          res,
  output logic [IDX_W-1:0]       res_index
);

  // Drain window geometry
  localparam int NW       = 3 * (BUF_DEPTH / 64);
  localparam int WW       = 3 * (BUF_DEPTH / 16);
  localparam int HALF     = BUF_DEPTH / 2;
  localparam int H_C      = 3 * (BUF_DEPTH / 4);
  localparam int F_C      = BUF_DEPTH / 4;

  localparam logic H_MID_ALL = (H_C < NW) ? 1'b1 : 1'b0;
  localparam logic F_MID_ALL = (F_C < NW) ? 1'b1 : 1'b0;
  localparam logic H_MIN_OK  = (H_C >= WW) ? 1'b1 : 1'b0;
  localparam logic F_MIN_OK  = (F_C >= WW) ? 1'b1 : 1'b0;

  localparam logic [PTR_W-1:0] H_MID_LO = PTR_W'((H_C >= NW) ? H_C - NW : 0);
  localparam logic [PTR_W-1:0] F_MID_LO = PTR_W'((F_C >= NW) ? F_C - NW : 0);
  localparam logic [PTR_W-1:0] H_MID_HI = PTR_W'(H_C + NW);
  localparam logic [PTR_W-1:0] F_MID_HI = PTR_W'(F_C + NW);
  localparam logic [PTR_W-1:0] H_MIN    = PTR_W'((H_C >= WW) ? H_C - WW : 0);
  localparam logic [PTR_W-1:0] F_MIN    = PTR_W'((F_C >= WW) ? F_C - WW : 0);
  localparam logic [PTR_W-1:0] H_MAX    = PTR_W'(H_C + WW);
  localparam logic [PTR_W-1:0] F_MAX    = PTR_W'(F_C + WW);
  localparam logic [PTR_W-1:0] P_HALF   = PTR_W'(HALF);
  localparam logic [PTR_W-1:0] P_DEPTH  = PTR_W'(BUF_DEPTH);

  logic [31:0]       last_edge_r, last_edge_nxt;
  logic [2:0]        rate_r, rate_nxt;
  arm_pkg::thr_set_t set_r, set_nxt;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [8:0]        mult_r, mult_nxt;

  arm_pkg::req_t     req;
  arm_pkg::thr_set_t eff_set;
  logic [31:0]       period;
  logic [2:0]        rate_cls;
  logic [PTR_W-1:0]  ptr_wrap;
  logic              is_half;
  logic              mid_hit, over_hit, min_hit, max_hit;

  // Period classification into rate code
  always_comb begin
    period = timestamp_us - last_edge_r;
    priority if (period >= 32'd22 && period <= 32'd26) rate_cls = arm_pkg::RATE_44K;
    else if (period >= 32'd20 && period <= 32'd21)     rate_cls = arm_pkg::RATE_48K;
    else if (period >= 32'd84 && period <= 32'd199)    rate_cls = arm_pkg::RATE_8K;
    else if (period >= 32'd56 && period <= 32'd83)     rate_cls = arm_pkg::RATE_16K;
    else if (period >= 32'd39 && period <= 32'd55)     rate_cls = arm_pkg::RATE_22K;
    else if (period >= 32'd27 && period <= 32'd38)     rate_cls = arm_pkg::RATE_33K;
    else                                               rate_cls = arm_pkg::RATE_NONE;
  end

  // Threshold set follows the detected rate when it is 8k, 44k or 48k
  always_comb begin
    priority if (rate_r == arm_pkg::RATE_8K) eff_set = arm_pkg::SET_8K;
    else if (rate_r == arm_pkg::RATE_44K)    eff_set = arm_pkg::SET_44K;
    else if (rate_r == arm_pkg::RATE_48K)    eff_set = arm_pkg::SET_48K;
    else                                     eff_set = set_r;
  end

  // Drain window tests on the unwrapped pointer
  always_comb begin
    is_half  = (req == arm_pkg::REQ_HALF);
    mid_hit  = is_half ? ((H_MID_ALL || ptr_r > H_MID_LO) && ptr_r < H_MID_HI)
                       : ((F_MID_ALL || ptr_r > F_MID_LO) && ptr_r < F_MID_HI);
    over_hit = is_half ? (ptr_r < P_HALF) : (ptr_r > P_HALF);
    min_hit  = is_half ? (H_MIN_OK && ptr_r < H_MIN) : (F_MIN_OK && ptr_r < F_MIN);
    max_hit  = is_half ? (ptr_r > H_MAX) : (ptr_r > F_MAX);
  end

  // Next state and result for the current transaction
  always_comb begin
    req           = arm_pkg::req_t'(req_type);
    ptr_wrap      = (ptr_r >= P_DEPTH) ? '0 : ptr_r;
    last_edge_nxt = last_edge_r;
    rate_nxt      = rate_r;
    set_nxt       = set_r;
    ptr_nxt       = ptr_r;
    mult_nxt      = mult_r;
    res           = '0;
    res_index     = '0;

    unique case (req)
      arm_pkg::REQ_EDGE: begin
        rate_nxt      = rate_cls;
        last_edge_nxt = timestamp_us;
      end
      arm_pkg::REQ_SAMPLE: begin
        set_nxt = eff_set;
        ptr_nxt = ptr_wrap + PTR_W'(1);
        if (mult_r > arm_pkg::thr_value(eff_set, arm_pkg::THR_OVR)) begin
          res.clear_buffer = 1'b1;
        end else begin
          res.write_enable = 1'b1;
          res.write_value  = sample_word[31:16];
          res_index        = ptr_wrap[IDX_W-1:0];
        end
      end
      arm_pkg::REQ_HALF, arm_pkg::REQ_FULL: begin
        set_nxt        = eff_set;
        res.pll_update = 1'b1;
        priority if (mid_hit) begin
          mult_nxt = arm_pkg::thr_value(eff_set, arm_pkg::THR_MID);
        end else if (over_hit) begin
          mult_nxt         = arm_pkg::thr_value(eff_set, arm_pkg::THR_OVR);
          res.clear_buffer = 1'b1;
        end else if (min_hit) begin
          mult_nxt = arm_pkg::thr_value(eff_set, arm_pkg::THR_MIN);
        end else if (max_hit) begin
          mult_nxt = arm_pkg::thr_value(eff_set, arm_pkg::THR_MAX);
        end else begin
          mult_nxt = mult_r;
        end
      end
      default: begin
        rate_nxt = rate_r;
      end
    endcase

    res.pll_mult  = mult_nxt;
    res.rate_code = rate_nxt;
  end

  // State registers, updated on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      rate_r      <= arm_pkg::RATE_44K;
      set_r       <= arm_pkg::SET_44K;
      ptr_r       <= '0;
      mult_r      <= arm_pkg::MULT_RESET;
    end else if (fire) begin
      last_edge_r <= last_edge_nxt;
      rate_r      <= rate_nxt;
      set_r       <= set_nxt;
      ptr_r       <= ptr_nxt;
      mult_r      <= mult_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/arm_out_buf.sv
`default_nettype none

// Result register with a skid stage behind it.
module arm_out_buf #(
  parameter int IDX_W = 7
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire arm_pkg::res_t    push_res,
  input  wire logic [IDX_W-1:0] push_index,
  output logic                  can_push,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output arm_pkg::res_t         out_res,
  output logic [IDX_W-1:0]      out_index
);

  logic               head_valid_r, head_valid_nxt;
  logic               skid_valid_r, skid_valid_nxt;
  arm_pkg::res_t      head_res_r, skid_res_r;
  logic [IDX_W-1:0]   head_idx_r, skid_idx_r;
  logic               pop;
  logic               load_head_new, load_head_skid, load_skid;

  assign can_push  = !skid_valid_r;
  assign out_valid = head_valid_r;
  assign out_res   = head_res_r;
  assign out_index = head_idx_r;
  assign pop       = head_valid_r && out_ready;

  // Slot steering
  always_comb begin
    head_valid_nxt = head_valid_r;
    skid_valid_nxt = skid_valid_r;
    load_head_new  = 1'b0;
    load_head_skid = 1'b0;
    load_skid      = 1'b0;
    if (pop) begin
      if (skid_valid_r) begin
        load_head_skid = 1'b1;
        skid_valid_nxt = 1'b0;
      end else if (push) begin
        load_head_new = 1'b1;
      end else begin
        head_valid_nxt = 1'b0;
      end
    end else if (push) begin
      if (!head_valid_r) begin
        load_head_new  = 1'b1;
        head_valid_nxt = 1'b1;
      end else begin
        load_skid      = 1'b1;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      head_valid_r <= head_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load_head_new) begin
      head_res_r <= push_res;
      head_idx_r <= push_index;
    end else if (load_head_skid) begin
      head_res_r <= skid_res_r;
      head_idx_r <= skid_idx_r;
    end
    if (load_skid) begin
      skid_res_r <= push_res;
      skid_idx_r <= push_index;
    end
  end

endmodule

`default_nettype wire

### rtl/audio_rate_match_controller_unit.sv
// Each result is registered in the result buffer when its input transaction is accepted.
// Throughput: one transaction per cycle while the result buffer is not full; the decision is a single pass over the
// controller state, and a two-entry result buffer keeps input open while a result waits.
// Reset (rst_n low, synchronous): rate 44k, 44k threshold set, pointer 0,
// multiplier 330, last edge time 0, result buffer empty.
`default_nettype none

module audio_rate_match_controller_unit #(
  parameter int BUF_DEPTH = arm_pkg::BUF_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [1:0]                   in_req_type,
  input  wire logic [31:0]                  in_timestamp_us,
  input  wire logic [31:0]                  in_sample_word,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic                              out_write_enable,
  output logic [$clog2(BUF_DEPTH)-1:0]      out_write_index,
  output logic [15:0]                       out_write_value,
  output logic                              out_clear_buffer,
  output logic                              out_pll_update,
  output logic [8:0]                        out_pll_mult,
  output logic [2:0]                        out_rate_code
);

  localparam int IDX_W = $clog2(BUF_DEPTH);
  localparam int PTR_W = $clog2(BUF_DEPTH + 1);

  logic             fire;
  arm_pkg::res_t    core_res, buf_res;
  logic [IDX_W-1:0] core_idx;

  assign fire = in_valid && in_ready;

  arm_core #(
    .BUF_DEPTH (BUF_DEPTH),
    .PTR_W     (PTR_W),
    .IDX_W     (IDX_W)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .req_type     (in_req_type),
    .timestamp_us (in_timestamp_us),
    .sample_word  (in_sample_word),
    .res          (core_res),
    .res_index    (core_idx)
  );

  arm_out_buf #(
    .IDX_W (IDX_W)
  ) u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (fire),
    .push_res   (core_res),
    .push_index (core_idx),
    .can_push   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (buf_res),
    .out_index  (out_write_index)
  );

  // Result fields
  assign out_write_enable = buf_res.write_enable;
  assign out_write_value  = buf_res.write_value;
  assign out_clear_buffer = buf_res.clear_buffer;
  assign out_pll_update   = buf_res.pll_update;
  assign out_pll_mult     = buf_res.pll_mult;
  assign out_rate_code    = buf_res.rate_code;

endmodule

`default_nettype wire

### tb/audio_rate_match_controller_unit_tb.sv
`default_nettype none

module audio_rate_match_controller_unit_tb;

  localparam int DEPTH       = arm_pkg::BUF_DEPTH_DEF;
  localparam int NEAR_WIN    = 3 * (DEPTH / 64);
  localparam int WIDE_WIN    = 3 * (DEPTH / 16);
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  // One expected result transaction
  typedef struct packed {
    logic        write_enable;
    logic [6:0]  write_index;
    logic [15:0] write_value;
    logic        clear_buffer;
    logic        pll_update;
    logic [8:0]  pll_mult;
    logic [2:0]  rate_code;
  } play_result_t;

  // Multiplier steps of one threshold set
  typedef struct packed {
    logic [8:0] lo;
    logic [8:0] mid;
    logic [8:0] hi;
    logic [8:0] ovr;
  } mult_limits_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_req_type = arm_pkg::REQ_EDGE;
  logic [31:0] in_timestamp_us = '0;
  logic [31:0] in_sample_word = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_write_enable;
  logic [6:0]  out_write_index;
  logic [15:0] out_write_value;
  logic        out_clear_buffer;
  logic        out_pll_update;
  logic [8:0]  out_pll_mult;
  logic [2:0]  out_rate_code;

  // Stimulus control
  logic        gaps_on = 1'b1;
  logic        hold_tgl = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  logic [31:0] sent_edge_stamp = '0;
  int          fail_count = 0;
  int          cycle_count = 0;

  // Predicted controller state, reset values
  logic [31:0]       edge_time_q = '0;
  logic [2:0]        rate_now = arm_pkg::RATE_44K;
  arm_pkg::thr_set_t active_set = arm_pkg::SET_44K;
  int                wr_ptr = 0;
  logic [8:0]        mult_now = arm_pkg::MULT_RESET;

  play_result_t expected_results[$];

  audio_rate_match_controller_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_req_type      (in_req_type),
    .in_timestamp_us  (in_timestamp_us),
    .in_sample_word   (in_sample_word),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_write_enable (out_write_enable),
    .out_write_index  (out_write_index),
    .out_write_value  (out_write_value),
    .out_clear_buffer (out_clear_buffer),
    .out_pll_update   (out_pll_update),
    .out_pll_mult     (out_pll_mult),
    .out_rate_code    (out_rate_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Edge period to rate code
  function automatic logic [2:0] period_to_rate(logic [31:0] p);
    if (p >= 22 && p <= 26) return arm_pkg::RATE_44K;
    if (p >= 20 && p <= 21) return arm_pkg::RATE_48K;
    if (p >= 84 && p <= 199) return arm_pkg::RATE_8K;
    if (p >= 56 && p <= 83) return arm_pkg::RATE_16K;
    if (p >= 39 && p <= 55) return arm_pkg::RATE_22K;
    if (p >= 27 && p <= 38) return arm_pkg::RATE_33K;
    return arm_pkg::RATE_NONE;
  endfunction

  function automatic mult_limits_t set_limits(arm_pkg::thr_set_t s);
    case (s)
      arm_pkg::SET_8K:  return '{lo: 9'd56,  mid: 9'd57,  hi: 9'd58,  ovr: 9'd60};
      arm_pkg::SET_48K: return '{lo: 9'd342, mid: 9'd343, hi: 9'd345, ovr: 9'd360};
      default:          return '{lo: 9'd315, mid: 9'd316, hi: 9'd317, ovr: 9'd320};
    endcase
  endfunction

  // Advance the predicted state by one input transaction
  function automatic play_result_t predict_transaction(arm_pkg::req_t kind, logic [31:0] ts,
                                                       logic [31:0] word);
    play_result_t r;
    mult_limits_t lim;
    int           centre;
    logic         half;
    logic         over;
    r = '0;
    if (kind == arm_pkg::REQ_EDGE) begin
      rate_now = period_to_rate(ts - edge_time_q);
      edge_time_q = ts;
    end else begin
      // set follows the rate lazily, only for 8k/44k/48k
      case (rate_now)
        arm_pkg::RATE_8K:  active_set = arm_pkg::SET_8K;
        arm_pkg::RATE_44K: active_set = arm_pkg::SET_44K;
        arm_pkg::RATE_48K: active_set = arm_pkg::SET_48K;
        default: ;
      endcase
      lim = set_limits(active_set);
      if (kind == arm_pkg::REQ_SAMPLE) begin
        if (wr_ptr >= DEPTH) wr_ptr = 0;
        if (mult_now > lim.ovr) begin
          r.clear_buffer = 1'b1;
        end else begin
          r.write_enable = 1'b1;
          r.write_index  = wr_ptr[6:0];
          r.write_value  = word[31:16];
        end
        wr_ptr++;
      end else begin
        r.pll_update = 1'b1;
        half = (kind == arm_pkg::REQ_HALF);
        centre = half ? 3 * (DEPTH / 4) : DEPTH / 4;
        over = half ? (wr_ptr < DEPTH / 2) : (wr_ptr > DEPTH / 2);
        if ((centre < NEAR_WIN || wr_ptr > centre - NEAR_WIN) && wr_ptr < centre + NEAR_WIN) begin
          mult_now = lim.mid;
        end else if (over) begin
          mult_now = lim.ovr;
          r.clear_buffer = 1'b1;
        end else if (centre >= WIDE_WIN && wr_ptr < centre - WIDE_WIN) begin
          mult_now = lim.lo;
        end else if (wr_ptr > centre + WIDE_WIN) begin
          mult_now = lim.hi;
        end
      end
    end
    r.pll_mult  = mult_now;
    r.rate_code = rate_now;
    return r;
  endfunction

  // Record expectations for accepted input transactions
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      expected_results.push_back(predict_transaction(arm_pkg::req_t'(in_req_type),
                                                     in_timestamp_us, in_sample_word));
  end

  task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Check each result transaction against the oldest expectation
  always @(posedge clk) begin
    play_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual mult %0d", $time,
                 out_pll_mult);
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        compare_field("write_enable", exp_r.write_enable, out_write_enable);
        compare_field("write_index", exp_r.write_index, out_write_index);
        compare_field("write_value", exp_r.write_value, out_write_value);
        compare_field("clear_buffer", exp_r.clear_buffer, out_clear_buffer);
        compare_field("pll_update", exp_r.pll_update, out_pll_update);
        compare_field("pll_mult", exp_r.pll_mult, out_pll_mult);
        compare_field("rate_code", exp_r.rate_code, out_rate_code);
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_tgl != hold_seen) begin
      hold_seen <= hold_tgl;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !gaps_on || ($urandom_range(99) >= 32);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("audio_rate_match_controller_unit regression: fail");
      $finish;
    end
  end

  // Offer one input transaction and wait until it is taken
  task automatic send_item(arm_pkg::req_t kind, logic [31:0] ts, logic [31:0] word);
    if (gaps_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= kind;
    in_timestamp_us <= ts;
    in_sample_word  <= word;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_edge_after(logic [31:0] period);
    sent_edge_stamp = sent_edge_stamp + period;
    send_item(arm_pkg::REQ_EDGE, sent_edge_stamp, $urandom);
  endtask

  task automatic send_random_item();
    logic [31:0] period;
    int          pick;
    pick = $urandom_range(99);
    if (pick < 15) begin
      case ($urandom_range(9))
        0, 1, 2: period = $urandom_range(26, 22);
        3, 4:    period = $urandom_range(21, 20);
        5:       period = $urandom_range(199, 84);
        6:       period = $urandom_range(83, 27);
        7:       period = $urandom_range(19, 0);
        8:       period = $urandom_range(4000, 200);
        default: period = $urandom;
      endcase
      send_edge_after(period);
    end else if (pick < 65) begin
      send_item(arm_pkg::REQ_SAMPLE, $urandom, $urandom);
    end else if (pick < 82) begin
      send_item(arm_pkg::REQ_HALF, $urandom, $urandom);
    end else begin
      send_item(arm_pkg::REQ_FULL, $urandom, $urandom);
    end
  endtask

  // Multiplier starts above the 44k overrun step: samples are dropped
  task automatic test_reset_overrun();
    send_item(arm_pkg::REQ_SAMPLE, 32'h0, 32'h0000_0000);
    send_item(arm_pkg::REQ_SAMPLE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_item(arm_pkg::REQ_SAMPLE, 32'h0, 32'h7FFF_8000);
  endtask

  // Period band edges, zero period and timestamp wrap
  task automatic test_rate_bands();
    logic [31:0] periods[16];
    periods = '{32'd0, 32'd19, 32'd20, 32'd21, 32'd22, 32'd26, 32'd27, 32'd38,
                32'd39, 32'd55, 32'd56, 32'd83, 32'd84, 32'd199, 32'd200, 32'd22};
    sent_edge_stamp = 32'hFFFF_FFF0;
    send_item(arm_pkg::REQ_EDGE, sent_edge_stamp, 32'h0);
    foreach (periods[i]) send_edge_after(periods[i]);
  endtask

  // Drain decisions at a low pointer, then a sample at the overrun step
  task automatic test_drain_events();
    send_item(arm_pkg::REQ_FULL, $urandom, $urandom);
    send_item(arm_pkg::REQ_HALF, $urandom, $urandom);
    send_item(arm_pkg::REQ_SAMPLE, $urandom, 32'hFFFF_0000);
    send_item(arm_pkg::REQ_SAMPLE, $urandom, 32'h0000_FFFF);
  endtask

  task automatic test_random_traffic();
    gaps_on <= 1'b1;
    repeat (1100) send_random_item();
  endtask

  task automatic test_steady_stream();
    gaps_on <= 1'b0;
    repeat (200) send_random_item();
    gaps_on <= 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering transactions
  task automatic test_backpressure();
    gaps_on <= 1'b0;
    hold_tgl <= ~hold_tgl;
    repeat (40) send_random_item();
    gaps_on <= 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_overrun();
    test_rate_bands();
    test_drain_events();
    test_random_traffic();
    test_steady_stream();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("audio_rate_match_controller_unit regression: pass");
    end else begin
      $display("audio_rate_match_controller_unit regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire
